// File: design/pfm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfm_pkg
// shared widths, constants, register indexes and control types for the
// period frequency meter
// ----------------------------------------------------------------------------
package pfm_pkg;

  localparam int TPU_W      = 8;
  localparam int TW_W       = 11;
  localparam int PER_W      = 32;
  localparam int FRQ_W      = 20;
  localparam int DIVISOR_W  = 20;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 11;

  localparam logic [FRQ_W-1:0]      US_PER_SECOND = 20'd1000000;
  localparam logic [TPU_W-1:0]      TPU_RESET     = 8'd16;
  localparam logic [TW_W-1:0]       TW_RESET      = 11'd1;

  localparam logic [CFG_IDX_W-1:0]  REG_TICKS_PER_US = 8'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_TICK_WEIGHT  = 8'd1;

  typedef struct packed {
    logic cnt_clear;
    logic cnt_tick;
    logic mul_load;
    logic div_start;
    logic div_freq;
    logic per_load;
    logic out_load;
  } pfm_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_full;
  } pfm_sts_t;

endpackage
`default_nettype wire

// File: design/pfm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfm channel interfaces
// sample, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface pfm_in_if;
  import pfm_pkg::*;
  logic valid;
  logic ready;
  logic signal_level;
  modport source (output valid, output signal_level, input ready);
  modport sink   (input valid, input signal_level, output ready);
endinterface

interface pfm_out_if;
  import pfm_pkg::*;
  logic             valid;
  logic             ready;
  logic [PER_W-1:0] period_us;
  logic [FRQ_W-1:0] frequency_hz;
  logic             too_short;
  logic             count_overflow;
  modport source (output valid, output period_us, output frequency_hz,
                  output too_short, output count_overflow, input ready);
  modport sink   (input valid, input period_us, input frequency_hz,
                  input too_short, input count_overflow, output ready);
endinterface

interface pfm_cfg_if;
  import pfm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: design/pfm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pfm_div #(
  parameter int DW = 43
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [DW-1:0]                 dividend,
  input  wire logic [pfm_pkg::DIVISOR_W-1:0] divisor,
  output logic                               done,
  output logic [DW-1:0]                      quotient
);
  import pfm_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic                 busy_r, busy_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [DW-1:0]        quo_r, quo_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [DIVISOR_W-1:0] dsr_r, dsr_nxt;
  logic [DIVISOR_W:0]   rem_sh;
  logic                 ge;

  assign rem_sh = {rem_r, quo_r[DW-1]};
  assign ge     = rem_sh >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DW-2:0], ge};
      rem_nxt = ge ? DIVISOR_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[DIVISOR_W-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = !busy_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// File: design/pfm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfm_ctrl
// sync and counting phases plus sequencing of multiply, divides and output
// ----------------------------------------------------------------------------
module pfm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_level,
  output logic                   in_ready,
  input  wire pfm_pkg::pfm_sts_t sts,
  output pfm_pkg::pfm_cmd_t      cmd
);
  import pfm_pkg::*;

  typedef enum logic [2:0] {
    ST_SYNC_HI,
    ST_SYNC_LO,
    ST_CNT_HI,
    ST_CNT_LO,
    ST_MUL,
    ST_PER_GO,
    ST_PER_WAIT,
    ST_FRQ_WAIT
  } state_t;

  state_t state_r, state_nxt;
  logic   acc;

  assign in_ready = (state_r == ST_SYNC_HI) || (state_r == ST_SYNC_LO) ||
                    (state_r == ST_CNT_HI)  || (state_r == ST_CNT_LO);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_SYNC_HI: begin
        if (acc && in_level) begin
          state_nxt = ST_SYNC_LO;
        end
      end
      ST_SYNC_LO: begin
        if (acc && !in_level) begin
          cmd.cnt_clear = 1'b1;
          state_nxt     = ST_CNT_HI;
        end
      end
      ST_CNT_HI: begin
        if (acc) begin
          cmd.cnt_tick = 1'b1;
          if (in_level) begin
            state_nxt = ST_CNT_LO;
          end
        end
      end
      ST_CNT_LO: begin
        if (acc) begin
          cmd.cnt_tick = 1'b1;
          if (!in_level) begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = ST_PER_GO;
      end
      ST_PER_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_PER_WAIT;
      end
      ST_PER_WAIT: begin
        if (sts.div_done) begin
          cmd.per_load  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_freq  = 1'b1;
          state_nxt     = ST_FRQ_WAIT;
        end
      end
      ST_FRQ_WAIT: begin
        if (sts.div_done && !sts.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_SYNC_HI;
        end
      end
      default: begin
        state_nxt = ST_SYNC_HI;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SYNC_HI;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/pfm_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfm_dp
// configuration registers, tick counter, multiplier, divider and output stage
// ----------------------------------------------------------------------------
module pfm_dp #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  input  wire logic [pfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pfm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire pfm_pkg::pfm_cmd_t               cmd,
  output pfm_pkg::pfm_sts_t                    sts,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic [pfm_pkg::PER_W-1:0]            out_period_us,
  output logic [pfm_pkg::FRQ_W-1:0]            out_frequency_hz,
  output logic                                 out_too_short,
  output logic                                 out_count_overflow
);
  import pfm_pkg::*;

  localparam int PW = COUNT_WIDTH + TW_W;
  localparam int EW = (PW > PER_W) ? PW : PER_W;

  logic [TPU_W-1:0]       tpu_r;
  logic [TW_W-1:0]        tw_r;
  logic [COUNT_WIDTH-1:0] count_r;
  logic                   ovf_r;
  logic [PW-1:0]          prod_r;
  logic [PW-1:0]          period_r;
  logic                   out_valid_r;
  logic [PER_W-1:0]       per_out_r;
  logic [FRQ_W-1:0]       frq_out_r;
  logic                   short_r;
  logic                   ovf_out_r;

  logic [TPU_W-1:0]       tpu_eff;
  logic [PW-1:0]          div_dividend;
  logic [DIVISOR_W-1:0]   div_divisor;
  logic                   div_done;
  logic [PW-1:0]          div_quo;
  logic [EW-1:0]          period_ext;
  logic                   per_zero;

  // the frequency divide starts in the cycle the period is loaded
  assign tpu_eff      = (tpu_r == '0) ? TPU_W'(1) : tpu_r;
  assign div_dividend = cmd.div_freq ? PW'(US_PER_SECOND) : prod_r;
  assign div_divisor  = cmd.div_freq ? div_quo[DIVISOR_W-1:0] : DIVISOR_W'(tpu_eff);

  pfm_div #(
    .DW(PW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign period_ext = EW'(period_r);
  assign per_zero   = period_r == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r <= TPU_RESET;
      tw_r  <= TW_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_TICKS_PER_US) begin
        tpu_r <= cfg_data[TPU_W-1:0];
      end else if (cfg_index == REG_TICK_WEIGHT) begin
        tw_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_clear) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.cnt_tick) begin
      if (count_r == '1) begin
        ovf_r <= 1'b1;
      end else begin
        count_r <= count_r + COUNT_WIDTH'(1);
      end
    end
    if (cmd.mul_load) begin
      prod_r <= PW'(count_r) * PW'(tw_r);
    end
    if (cmd.per_load) begin
      period_r <= div_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      per_out_r <= (period_ext > EW'(32'hFFFF_FFFF)) ? '1 : period_ext[PER_W-1:0];
      frq_out_r <= (per_zero || period_r > PW'(US_PER_SECOND)) ? '0 : div_quo[FRQ_W-1:0];
      short_r   <= per_zero;
      ovf_out_r <= ovf_r;
    end
  end

  assign sts.div_done       = div_done;
  assign sts.out_full       = out_valid_r;
  assign out_valid          = out_valid_r;
  assign out_period_us      = per_out_r;
  assign out_frequency_hz   = frq_out_r;
  assign out_too_short      = short_r;
  assign out_count_overflow = ovf_out_r;

endmodule
`default_nettype wire

// File: design/period_frequency_meter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// period_frequency_meter
// measures the period of a sampled signal and derives its frequency
//
// in_ch takes one signal sample per transaction. the block syncs on a high
// then low level, then counts samples over one full high/low period, counting
// the sample that sees the closing low level.
// that closing sample starts the arithmetic: count * tick_weight, then two
// bit-serial divides (by ticks_per_us, then 1000000 by the period), after
// which the result is loaded onto out_ch. in_ch.ready is low meanwhile; at
// other times one sample is taken per cycle.
// the result sits in an output register: sampling resumes while it waits,
// and a later result waits for the receiver before the block takes more
// samples. cfg_ch is always ready; index 0 is ticks_per_us, index 1 is
// tick_weight, other indexes are ignored. reset restores 16 and 1, drops
// any pending result and restarts the sync.
// ----------------------------------------------------------------------------
module period_frequency_meter #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pfm_in_if.sink     in_ch,
  pfm_out_if.source  out_ch,
  pfm_cfg_if.sink    cfg_ch
);
  import pfm_pkg::*;

  pfm_cmd_t cmd;
  pfm_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  pfm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_level (in_ch.signal_level),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfm_dp #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_ch.valid),
    .cfg_index          (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .cmd                (cmd),
    .sts                (sts),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_period_us      (out_ch.period_us),
    .out_frequency_hz   (out_ch.frequency_hz),
    .out_too_short      (out_ch.too_short),
    .out_count_overflow (out_ch.count_overflow)
  );

endmodule
`default_nettype wire

// File: design/pfm_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfm_chk
// port-level checks on the result channel of the period frequency meter
// ----------------------------------------------------------------------------
module pfm_chk (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [pfm_pkg::PER_W-1:0]    period_us,
  input wire logic [pfm_pkg::FRQ_W-1:0]    frequency_hz,
  input wire logic                         too_short
);
  import pfm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(period_us) &&
                               $stable(frequency_hz))
    else $error("result dropped or changed while stalled");

  a_short_freq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && too_short |-> frequency_hz == '0)
    else $error("zero period with nonzero frequency");

  a_short_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> too_short == (period_us == '0))
    else $error("too_short disagrees with period");

  a_freq_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> frequency_hz <= US_PER_SECOND)
    else $error("frequency above one million");

  a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("results in consecutive cycles");

endmodule

bind period_frequency_meter pfm_chk u_pfm_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .period_us    (out_ch.period_us),
  .frequency_hz (out_ch.frequency_hz),
  .too_short    (out_ch.too_short)
);
`default_nettype wire
